// ----- hdl/whp_pkg.sv -----
// shared constants, codes and types of the weighted pair histogram
package whp_pkg;

   // matrix and class dimensions
   localparam int SIDE_MAX    = 64;
   localparam int CLASS_COUNT = 16;
   localparam int CELL_W      = 48;

   // item field widths
   localparam int ACTION_W = 2;
   localparam int CLASS_W  = 4;
   localparam int WEIGHT_W = 32;
   localparam int CODE_W   = 26;
   localparam int CADDR_W  = 12;
   localparam int STATUS_W = 2;
   localparam int OUT_W    = 48;
   localparam int CFG_W    = 7;

   // derived sizes
   localparam int CELL_COUNT = SIDE_MAX * SIDE_MAX;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int SIDE_W     = $clog2(SIDE_MAX + 1);
   localparam int SQ_W       = $clog2(CELL_COUNT + 1);
   localparam int SIDE_CMP_W = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
   localparam int RD_CMP_W   = (SQ_W > CADDR_W) ? SQ_W : CADDR_W;

   // path code split: col = (code * RECIP) >> RECIP_SHIFT, exact for 26 bit codes
   localparam int CODE_SPLIT  = 1000000;
   localparam int RECIP_W     = 27;
   localparam logic [RECIP_W-1:0] RECIP = 27'd70368745;
   localparam int RECIP_SHIFT = 46;
   localparam int PROD_W      = CODE_W + RECIP_W;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 20;
   localparam int COL_CMP_W   = (COL_W > SIDE_W) ? COL_W : SIDE_W;

   // actions of an input item
   typedef enum logic [ACTION_W-1:0] {
      ACT_SET_WEIGHT = 2'd0,
      ACT_ACCUM      = 2'd1,
      ACT_READ       = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_CLASS = 2'd2
   } status_type;

   // splitter result
   typedef struct packed {
      logic              valid;
      logic              ok;
      logic [ADDR_W-1:0] addr;
   } split_rsp_type;

   // cell store command
   typedef struct packed {
      logic                valid;
      logic                accum;
      logic [ADDR_W-1:0]   addr;
      logic [WEIGHT_W-1:0] addend;
   } store_cmd_type;

   // cell store result
   typedef struct packed {
      logic              valid;
      logic [CELL_W-1:0] value;
   } store_rsp_type;

endpackage

// ----- hdl/whp_if.sv -----
// request and response channel interfaces
interface whp_req_if;
   import whp_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CLASS_W-1:0]  class_index;
   logic [WEIGHT_W-1:0] weight_value;
   logic [CODE_W-1:0]   path_code;
   logic [CADDR_W-1:0]  cell_address;

   modport source (
      output valid, action, class_index, weight_value, path_code, cell_address,
      input  ready
   );
   modport sink (
      input  valid, action, class_index, weight_value, path_code, cell_address,
      output ready
   );
endinterface

interface whp_rsp_if;
   import whp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OUT_W-1:0]    cell_value;

   modport source (
      output valid, status, cell_value,
      input  ready
   );
   modport sink (
      input  valid, status, cell_value,
      output ready
   );
endinterface

// ----- hdl/whp_code_split.sv -----
// path code splitter: column, row, range check and cell address over three stages
module whp_code_split (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [whp_pkg::CODE_W-1:0]    code,
   input  logic [whp_pkg::SIDE_W-1:0]    side,
   output whp_pkg::split_rsp_type        result
);
   import whp_pkg::*;

   logic                  s1_valid_ff;
   logic [PROD_W-1:0]     s1_prod_ff;
   logic [PROD_W-1:0]     s1_prod_in;
   logic [CODE_W-1:0]     s1_code_ff;
   logic                  s2_valid_ff;
   logic [COL_W-1:0]      s2_col_ff;
   logic [COL_W-1:0]      s2_col_in;
   logic [ROW_W-1:0]      s2_row_ff;
   logic [ROW_W-1:0]      s2_row_in;
   logic                  s3_valid_ff;
   logic                  s3_ok_ff;
   logic                  s3_ok_in;
   logic [ADDR_W-1:0]     s3_addr_ff;
   logic [ADDR_W-1:0]     s3_addr_in;
   logic [CODE_W-1:0]     col_scaled;
   logic [SIDE_W-1:0]     row_m1;
   logic [SIDE_W-1:0]     col_m1;
   logic [2*SIDE_W-1:0]   addr_full;

   // stage 1: multiply by the reciprocal of the split constant
   assign s1_prod_in = PROD_W'(code) * PROD_W'(RECIP);

   // stage 2: quotient is the column, remainder is the row
   assign s2_col_in  = s1_prod_ff[RECIP_SHIFT +: COL_W];
   assign col_scaled = CODE_W'(s2_col_in) * CODE_W'(CODE_SPLIT);
   assign s2_row_in  = ROW_W'(s1_code_ff - col_scaled);

   // stage 3: range check and row major address
   assign s3_ok_in = (s2_row_ff != '0) && (s2_row_ff <= ROW_W'(side))
                  && (s2_col_ff != '0) && (COL_CMP_W'(s2_col_ff) <= COL_CMP_W'(side));
   assign row_m1     = SIDE_W'(s2_row_ff - 1'b1);
   assign col_m1     = SIDE_W'(s2_col_ff - 1'b1);
   assign addr_full  = (2*SIDE_W)'(row_m1) * (2*SIDE_W)'(side) + (2*SIDE_W)'(col_m1);
   assign s3_addr_in = addr_full[ADDR_W-1:0];

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s1_code_ff <= code;
      s2_col_ff  <= s2_col_in;
      s2_row_ff  <= s2_row_in;
      s3_ok_ff   <= s3_ok_in;
      s3_addr_ff <= s3_addr_in;
   end

   assign result.valid = s3_valid_ff;
   assign result.ok    = s3_ok_ff;
   assign result.addr  = s3_addr_ff;

endmodule

// ----- hdl/whp_cell_store.sv -----
// accumulator cell memory with clearing pass and saturating read-modify-write
module whp_cell_store (
   input  logic                   clock,
   input  logic                   reset,
   input  whp_pkg::store_cmd_type cmd,
   output whp_pkg::store_rsp_type rsp,
   output logic                   clear_busy
);
   import whp_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

   logic [CELL_W-1:0]   mem [CELL_COUNT];
   logic [CELL_W-1:0]   rdata_ff;
   logic                clr_busy_ff;
   logic [ADDR_W-1:0]   clr_ptr_ff;
   logic                p1_valid_ff;
   logic                p1_accum_ff;
   logic [ADDR_W-1:0]   p1_addr_ff;
   logic [WEIGHT_W-1:0] p1_addend_ff;
   logic [CELL_W:0]     sum_full;
   logic [CELL_W-1:0]   sum_sat;
   logic                wr_en;

   // saturating add of the class weight onto the cell read last cycle
   assign sum_full = (CELL_W+1)'(rdata_ff) + (CELL_W+1)'(p1_addend_ff);
   assign sum_sat  = sum_full[CELL_W] ? '1 : sum_full[CELL_W-1:0];
   assign wr_en    = p1_valid_ff && p1_accum_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_ptr_ff] <= '0;
      end else if (wr_en) begin
         mem[p1_addr_ff] <= sum_sat;
      end
      rdata_ff <= mem[cmd.addr];
   end

   // clearing pass after reset, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == LAST_ADDR) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // command held for the write-back cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.valid;
      end
      p1_accum_ff  <= cmd.accum;
      p1_addr_ff   <= cmd.addr;
      p1_addend_ff <= cmd.addend;
   end

   assign rsp.valid  = p1_valid_ff;
   assign rsp.value  = p1_accum_ff ? sum_sat : rdata_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ----- hdl/weighted_pair_histogram.sv -----
// weighted pair histogram: scatter-add of class weights into a square cell matrix
// set weight, bad class and no-op results pass the result slot and the output register; a read
// passes the memory read first, an accumulate the 3 split stages, then memory read and write
// set weight 1 item per cycle while rsp_ch is ready; reads and accumulates do not overlap
// reset: weights zero, side 64; the 4096-entry cell memory is then cleared entry by entry,
// during which no item is accepted and configuration writes are still taken
module weighted_pair_histogram (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [whp_pkg::CFG_W-1:0]  csr_write_data,
   whp_req_if.sink                    req_ch,
   whp_rsp_if.source                  rsp_ch
);
   import whp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_STORE
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [SIDE_W-1:0]   side_ff;
   logic [SIDE_W-1:0]   side_in;
   logic [SQ_W-1:0]     side_sq_ff;
   logic [SQ_W-1:0]     side_sq_in;
   logic [WEIGHT_W-1:0] weights_ff [CLASS_COUNT];
   logic [WEIGHT_W-1:0] weight_ff;
   logic                res_valid_ff;
   logic                res_valid_in;
   status_type          res_status_ff;
   status_type          res_status_in;
   logic [OUT_W-1:0]    res_value_ff;
   logic [OUT_W-1:0]    res_value_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          rsp_status_ff;
   logic [OUT_W-1:0]    rsp_value_ff;

   logic [SIDE_CMP_W-1:0] csr_ext;
   logic [SIDE_CMP_W-1:0] csr_clamped;
   logic [2*SIDE_W-1:0]   side_sq_full;
   logic                  req_accept;
   logic                  rsp_load;
   logic                  res_free;
   logic                  cls_bad;
   logic                  rd_ok;
   logic                  split_start;
   logic                  weight_write;
   logic                  clear_busy;
   action_type            req_action;
   split_rsp_type         split_rsp;
   store_cmd_type         st_cmd;
   store_rsp_type         st_rsp;

   whp_code_split u_split (
      .clock  (clock),
      .reset  (reset),
      .start  (split_start),
      .code   (req_ch.path_code),
      .side   (side_ff),
      .result (split_rsp)
   );

   whp_cell_store u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (st_cmd),
      .rsp        (st_rsp),
      .clear_busy (clear_busy)
   );

   // side limited to the matrix size, and its square for the read check
   assign csr_ext      = SIDE_CMP_W'(csr_write_data);
   assign csr_clamped  = (csr_ext > SIDE_CMP_W'(SIDE_MAX)) ? SIDE_CMP_W'(SIDE_MAX) : csr_ext;
   assign side_in      = SIDE_W'(csr_clamped);
   assign side_sq_full = (2*SIDE_W)'(side_in) * (2*SIDE_W)'(side_in);
   assign side_sq_in   = side_sq_full[SQ_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff    <= SIDE_W'(SIDE_MAX);
         side_sq_ff <= SQ_W'(CELL_COUNT);
      end else if (csr_write_en) begin
         side_ff    <= side_in;
         side_sq_ff <= side_sq_in;
      end
   end

   // handshake and item decode
   assign req_action   = action_type'(req_ch.action);
   assign rsp_load     = res_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign res_free     = !res_valid_ff || rsp_load;
   assign req_ch.ready = (state_ff == ST_IDLE) && !clear_busy && res_free;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign cls_bad      = ({1'b0, req_ch.class_index} >= (CLASS_W+1)'(CLASS_COUNT));
   assign rd_ok        = RD_CMP_W'(req_ch.cell_address) < RD_CMP_W'(side_sq_ff);
   assign split_start  = req_accept && (req_action == ACT_ACCUM) && !cls_bad;
   assign weight_write = req_accept && (req_action == ACT_SET_WEIGHT) && !cls_bad;

   // class weight table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            weights_ff[i] <= '0;
         end
      end else if (weight_write) begin
         weights_ff[req_ch.class_index] <= req_ch.weight_value;
      end
   end

   // weight of the class being accumulated
   always_ff @(posedge clock) begin
      if (split_start) begin
         weight_ff <= weights_ff[req_ch.class_index];
      end
   end

   // cell store commands: reads from idle, accumulates once the address is known
   always_comb begin
      st_cmd = '0;
      if ((state_ff == ST_IDLE) && req_accept && (req_action == ACT_READ) && rd_ok) begin
         st_cmd.valid = 1'b1;
         st_cmd.accum = 1'b0;
         st_cmd.addr  = ADDR_W'(req_ch.cell_address);
      end else if ((state_ff == ST_SPLIT) && split_rsp.valid && split_rsp.ok) begin
         st_cmd.valid  = 1'b1;
         st_cmd.accum  = 1'b1;
         st_cmd.addr   = split_rsp.addr;
         st_cmd.addend = weight_ff;
      end
   end

   // sequencer and result slot
   always_comb begin
      state_in      = state_ff;
      res_valid_in  = res_valid_ff && !rsp_load;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  ACT_SET_WEIGHT: begin
                     res_valid_in  = 1'b1;
                     res_status_in = cls_bad ? STATUS_CLASS : STATUS_OK;
                     res_value_in  = '0;
                  end
                  ACT_ACCUM: begin
                     if (cls_bad) begin
                        res_valid_in  = 1'b1;
                        res_status_in = STATUS_CLASS;
                        res_value_in  = '0;
                     end else begin
                        state_in = ST_SPLIT;
                     end
                  end
                  ACT_READ: begin
                     if (rd_ok) begin
                        state_in = ST_STORE;
                     end else begin
                        res_valid_in  = 1'b1;
                        res_status_in = STATUS_RANGE;
                        res_value_in  = '0;
                     end
                  end
                  default: begin
                     res_valid_in  = 1'b1;
                     res_status_in = STATUS_OK;
                     res_value_in  = '0;
                  end
               endcase
            end
         end
         ST_SPLIT: begin
            if (split_rsp.valid) begin
               if (split_rsp.ok) begin
                  state_in = ST_STORE;
               end else begin
                  state_in      = ST_IDLE;
                  res_valid_in  = 1'b1;
                  res_status_in = STATUS_RANGE;
                  res_value_in  = '0;
               end
            end
         end
         ST_STORE: begin
            if (st_rsp.valid) begin
               state_in      = ST_IDLE;
               res_valid_in  = 1'b1;
               res_status_in = STATUS_OK;
               res_value_in  = OUT_W'(st_rsp.value);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.cell_value = rsp_value_ff;

   // store results only come back while the sequencer waits for them
   a_store_rsp_state: assert property (@(posedge clock) disable iff (reset)
      st_rsp.valid |-> (state_ff == ST_STORE))
      else $error("cell store result outside store wait");

   // splitter results only come back while the sequencer waits for them
   a_split_rsp_state: assert property (@(posedge clock) disable iff (reset)
      split_rsp.valid |-> (state_ff == ST_SPLIT))
      else $error("split result outside split wait");

   // a pending result is never overwritten before it moves to the output
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && !rsp_load) |=> (res_valid_ff && $stable(res_value_ff)))
      else $error("pending result lost or changed");

endmodule
